// File: src/jsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape package
// Result kinds, error codes, result beat and bundle types, UTF-8 encoder.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // Result kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERR   = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NO_QUOTE  = 3'd0;
    localparam logic [2:0] ERR_UNTERM    = 3'd1;
    localparam logic [2:0] ERR_CTRL      = 3'd2;
    localparam logic [2:0] ERR_TRAIL_BSL = 3'd3;
    localparam logic [2:0] ERR_BAD_ESC   = 3'd4;
    localparam logic [2:0] ERR_TRUNC_HEX = 3'd5;
    localparam logic [2:0] ERR_BAD_HEX   = 3'd6;

    // Results per input item and default bundle queue depth
    localparam int MAX_RES     = 4;
    localparam int IDX_W       = 2;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] err;
    } t_result;

    // Up to four results of one item; last holds the index of the final one
    typedef struct packed {
        logic [IDX_W-1:0]          last;
        t_result [MAX_RES-1:0]     res;
    } t_bundle;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] bytes;
    } t_utf8;

    function automatic t_result make_byte(input logic [7:0] b);
        t_result r;
        r.kind = KIND_BYTE;
        r.data = b;
        r.err  = 3'd0;
        return r;
    endfunction

    function automatic t_result make_err(input logic [2:0] code);
        t_result r;
        r.kind = KIND_ERR;
        r.data = 8'd0;
        r.err  = code;
        return r;
    endfunction

    function automatic t_result make_close();
        t_result r;
        r.kind = KIND_CLOSE;
        r.data = 8'd0;
        r.err  = 3'd0;
        return r;
    endfunction

    // Encode a code point as 1 to 4 UTF-8 bytes, first byte in slot 0
    function automatic t_utf8 utf8_encode(input logic [20:0] cp);
        t_utf8 u;
        u.bytes = '0;
        if (cp <= 21'h7F) begin
            u.len      = 3'd1;
            u.bytes[0] = cp[7:0];
        end else if (cp <= 21'h7FF) begin
            u.len      = 3'd2;
            u.bytes[0] = {3'b110, cp[10:6]};
            u.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hFFFF) begin
            u.len      = 3'd3;
            u.bytes[0] = {4'b1110, cp[15:12]};
            u.bytes[1] = {2'b10, cp[11:6]};
            u.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            u.len      = 3'd4;
            u.bytes[0] = {5'b11110, cp[20:18]};
            u.bytes[1] = {2'b10, cp[17:12]};
            u.bytes[2] = {2'b10, cp[11:6]};
            u.bytes[3] = {2'b10, cp[5:0]};
        end
        return u;
    endfunction

endpackage

// File: src/jsu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape front end
// Scans one text beat per cycle and packs the results it causes into a bundle.
// ----------------------------------------------------------------------------
module jsu_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_in_byte,
    input  logic             i_end_of_text,
    output logic             o_bundle_valid,
    output jsu_pkg::t_bundle o_bundle,
    output logic             o_at_rest
);

    localparam logic [3:0] M_IDLE        = 4'd0;
    localparam logic [3:0] M_BODY        = 4'd1;
    localparam logic [3:0] M_ESC         = 4'd2;
    localparam logic [3:0] M_HEX         = 4'd3;
    localparam logic [3:0] M_HEX_BAD     = 4'd4;
    localparam logic [3:0] M_AFTER_HIGH  = 4'd5;
    localparam logic [3:0] M_HIGH_ESC    = 4'd6;
    localparam logic [3:0] M_LOW_HEX     = 4'd7;
    localparam logic [3:0] M_LOW_HEX_BAD = 4'd8;
    localparam logic [3:0] M_CLOSED      = 4'd9;

    localparam logic [20:0] CP_REPL = 21'h00FFFD;

    logic [3:0]  r_mode, n_mode;
    logic [15:0] r_hex, n_hex;
    logic [1:0]  r_hcnt, n_hcnt;
    logic [9:0]  r_high, n_high;
    logic        r_err_hold, n_err_hold;

    logic                         pre_repl;
    logic [3:0]                   eff_mode;
    logic [2:0]                   m_cnt;
    jsu_pkg::t_result [3:0]       m_res;
    jsu_pkg::t_utf8               enc;
    logic                         digit_ok;
    logic [3:0]                   digit;
    logic [15:0]                  hex_next;
    logic                         hex_bad;
    logic                         hex_low;
    logic [2:0]                   total;
    logic [7:0]                   b;

    // Decode the current hex digit
    always_comb begin
        b        = i_in_byte;
        digit_ok = 1'b1;
        digit    = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            digit = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            digit = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            digit = 4'(b - 8'h37);
        end else begin
            digit_ok = 1'b0;
        end
        hex_next = {r_hex[11:0], digit};
    end

    // Step the scanner and collect the results of this beat
    always_comb begin
        n_mode     = r_mode;
        n_hex      = r_hex;
        n_hcnt     = r_hcnt;
        n_high     = r_high;
        n_err_hold = r_err_hold;
        pre_repl   = 1'b0;
        m_cnt      = 3'd0;
        m_res      = '0;
        enc        = jsu_pkg::utf8_encode(CP_REPL);
        hex_bad    = (r_mode == M_HEX_BAD) || (r_mode == M_LOW_HEX_BAD);
        hex_low    = (r_mode == M_LOW_HEX) || (r_mode == M_LOW_HEX_BAD);
        eff_mode   = r_mode;

        if (i_end_of_text) begin
            // Report what is pending, then return to the reset state
            if (!r_err_hold) begin
                case (r_mode)
                    M_IDLE: begin
                        m_cnt = 3'd1; m_res[0] = jsu_pkg::make_err(jsu_pkg::ERR_NO_QUOTE);
                    end
                    M_BODY: begin
                        m_cnt = 3'd1; m_res[0] = jsu_pkg::make_err(jsu_pkg::ERR_UNTERM);
                    end
                    M_ESC: begin
                        m_cnt = 3'd1; m_res[0] = jsu_pkg::make_err(jsu_pkg::ERR_TRAIL_BSL);
                    end
                    M_HEX, M_HEX_BAD, M_LOW_HEX, M_LOW_HEX_BAD: begin
                        m_cnt = 3'd1; m_res[0] = jsu_pkg::make_err(jsu_pkg::ERR_TRUNC_HEX);
                    end
                    M_AFTER_HIGH: begin
                        pre_repl = 1'b1;
                        m_cnt = 3'd1; m_res[0] = jsu_pkg::make_err(jsu_pkg::ERR_UNTERM);
                    end
                    M_HIGH_ESC: begin
                        pre_repl = 1'b1;
                        m_cnt = 3'd1; m_res[0] = jsu_pkg::make_err(jsu_pkg::ERR_TRAIL_BSL);
                    end
                    default: begin
                        m_cnt = 3'd0;
                    end
                endcase
            end
            n_mode     = M_IDLE;
            n_hex      = 16'd0;
            n_hcnt     = 2'd0;
            n_high     = 10'd0;
            n_err_hold = 1'b0;
        end else if (!r_err_hold) begin
            // An unpaired high surrogate gives U+FFFD, then the beat is rescanned
            if (r_mode == M_AFTER_HIGH && b != 8'h5C) begin
                pre_repl = 1'b1;
                eff_mode = M_BODY;
            end else if (r_mode == M_HIGH_ESC && b != 8'h75) begin
                pre_repl = 1'b1;
                eff_mode = M_ESC;
            end

            case (eff_mode)
                M_IDLE: begin
                    if (b == 8'h22) begin
                        n_mode = M_BODY;
                    end else begin
                        m_cnt = 3'd1; m_res[0] = jsu_pkg::make_err(jsu_pkg::ERR_NO_QUOTE);
                        n_err_hold = 1'b1;
                        n_mode = M_IDLE;
                    end
                end
                M_BODY: begin
                    if (b == 8'h22) begin
                        m_cnt = 3'd1; m_res[0] = jsu_pkg::make_close();
                        n_mode = M_CLOSED;
                    end else if (b < 8'h20) begin
                        m_cnt = 3'd1; m_res[0] = jsu_pkg::make_err(jsu_pkg::ERR_CTRL);
                        n_err_hold = 1'b1;
                        n_mode = M_IDLE;
                    end else if (b == 8'h5C) begin
                        n_mode = M_ESC;
                    end else begin
                        m_cnt = 3'd1; m_res[0] = jsu_pkg::make_byte(b);
                        n_mode = M_BODY;
                    end
                end
                M_ESC: begin
                    n_mode = M_BODY;
                    m_cnt  = 3'd1;
                    case (b)
                        8'h22:   m_res[0] = jsu_pkg::make_byte(8'h22);
                        8'h5C:   m_res[0] = jsu_pkg::make_byte(8'h5C);
                        8'h2F:   m_res[0] = jsu_pkg::make_byte(8'h2F);
                        8'h62:   m_res[0] = jsu_pkg::make_byte(8'h08);
                        8'h66:   m_res[0] = jsu_pkg::make_byte(8'h0C);
                        8'h6E:   m_res[0] = jsu_pkg::make_byte(8'h0A);
                        8'h72:   m_res[0] = jsu_pkg::make_byte(8'h0D);
                        8'h74:   m_res[0] = jsu_pkg::make_byte(8'h09);
                        8'h75: begin
                            m_cnt  = 3'd0;
                            n_hex  = 16'd0;
                            n_hcnt = 2'd0;
                            n_mode = M_HEX;
                        end
                        default: begin
                            m_res[0]   = jsu_pkg::make_err(jsu_pkg::ERR_BAD_ESC);
                            n_err_hold = 1'b1;
                            n_mode     = M_IDLE;
                        end
                    endcase
                end
                M_HEX, M_HEX_BAD, M_LOW_HEX, M_LOW_HEX_BAD: begin
                    if (digit_ok) begin
                        n_hex = hex_next;
                    end
                    if (r_hcnt == 2'd3) begin
                        n_hcnt = 2'd0;
                        if (hex_bad || !digit_ok) begin
                            m_cnt = 3'd1; m_res[0] = jsu_pkg::make_err(jsu_pkg::ERR_BAD_HEX);
                            n_err_hold = 1'b1;
                            n_mode = M_IDLE;
                        end else begin
                            n_mode = M_BODY;
                            if (!hex_low) begin
                                if (hex_next[15:10] == 6'b110110) begin
                                    // Hold the high half and wait for its partner
                                    n_high = hex_next[9:0];
                                    n_mode = M_AFTER_HIGH;
                                end else if (hex_next[15:10] == 6'b110111) begin
                                    enc = jsu_pkg::utf8_encode(CP_REPL);
                                end else begin
                                    enc = jsu_pkg::utf8_encode({5'd0, hex_next});
                                end
                            end else if (hex_next[15:10] == 6'b110111) begin
                                enc = jsu_pkg::utf8_encode(21'h010000 +
                                                          {1'b0, r_high, hex_next[9:0]});
                            end else begin
                                enc = jsu_pkg::utf8_encode(CP_REPL);
                            end
                            if (n_mode == M_BODY) begin
                                m_cnt = enc.len;
                                for (int k = 0; k < 4; k++) begin
                                    m_res[k] = jsu_pkg::make_byte(enc.bytes[k]);
                                end
                            end
                        end
                    end else begin
                        n_hcnt = r_hcnt + 2'd1;
                        if (hex_low) begin
                            n_mode = (hex_bad || !digit_ok) ? M_LOW_HEX_BAD : M_LOW_HEX;
                        end else begin
                            n_mode = (hex_bad || !digit_ok) ? M_HEX_BAD : M_HEX;
                        end
                    end
                end
                M_AFTER_HIGH: begin
                    n_mode = M_HIGH_ESC;
                end
                M_HIGH_ESC: begin
                    n_hex  = 16'd0;
                    n_hcnt = 2'd0;
                    n_mode = M_LOW_HEX;
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase
        end
    end

    // Assemble the bundle, replacement character first when flagged
    always_comb begin
        o_bundle = '0;
        if (pre_repl) begin
            o_bundle.res[0] = jsu_pkg::make_byte(8'hEF);
            o_bundle.res[1] = jsu_pkg::make_byte(8'hBF);
            o_bundle.res[2] = jsu_pkg::make_byte(8'hBD);
            o_bundle.res[3] = m_res[0];
            total           = 3'd3 + m_cnt;
        end else begin
            o_bundle.res = m_res;
            total        = m_cnt;
        end
        o_bundle.last  = jsu_pkg::IDX_W'(total - 3'd1);
        o_bundle_valid = i_valid && (total != 3'd0);
    end

    assign o_at_rest = (r_mode == M_IDLE) && !r_err_hold;

    // Advance scanner state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_IDLE;
            r_hex      <= 16'd0;
            r_hcnt     <= 2'd0;
            r_high     <= 10'd0;
            r_err_hold <= 1'b0;
        end else if (i_valid) begin
            r_mode     <= n_mode;
            r_hex      <= n_hex;
            r_hcnt     <= n_hcnt;
            r_high     <= n_high;
            r_err_hold <= n_err_hold;
        end
    end

endmodule

// File: src/jsu_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape bundle queue
// Short first-in first-out store of result bundles between front and back.
// ----------------------------------------------------------------------------
module jsu_queue #(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  jsu_pkg::t_bundle i_wr_data,
    input  logic             i_rd,
    output jsu_pkg::t_bundle o_rd_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    jsu_pkg::t_bundle r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_wr;
    logic             do_rd;

    assign o_full    = (r_count == CNT_FULL);
    assign o_empty   = (r_count == '0);
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    // Store bundles
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: src/jsu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape back end
// Holds one bundle and hands out its results one beat per cycle while popped.
// ----------------------------------------------------------------------------
module jsu_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  jsu_pkg::t_bundle i_bundle,
    input  logic             i_bundle_empty,
    output logic             o_bundle_rd,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [1:0]       o_out_kind,
    output logic [7:0]       o_out_byte,
    output logic [2:0]       o_err_code,
    output logic             o_last_of_run
);

    logic                      r_valid;
    jsu_pkg::t_bundle          r_bundle;
    logic [jsu_pkg::IDX_W-1:0] r_idx;
    logic                      at_last;
    logic                      take;
    jsu_pkg::t_result          cur;

    assign at_last     = (r_idx == r_bundle.last);
    assign take        = !r_valid || (i_pop && at_last);
    assign o_bundle_rd = take && !i_bundle_empty;

    // Present the current result
    assign cur           = r_bundle.res[r_idx];
    assign o_empty       = !r_valid;
    assign o_out_kind    = cur.kind;
    assign o_out_byte    = cur.data;
    assign o_err_code    = cur.err;
    assign o_last_of_run = at_last;

    // Hold bundle payload
    always_ff @(posedge i_clk) begin
        if (o_bundle_rd) begin
            r_bundle <= i_bundle;
        end
    end

    // Step through results; refill from the queue after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (take) begin
            r_valid <= !i_bundle_empty;
            r_idx   <= '0;
        end else if (i_pop) begin
            r_idx <= r_idx + 1'b1;
        end
    end

endmodule

// File: src/json_string_unescape_utf8_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape to UTF-8, top level
// Path: results are stored in the bundle queue, then in the output register.
// Throughput: one input beat per cycle; results leave one per cycle while
//   popped from the output register, so items with several results fill the
//   bundle queue and hold the input side off through full.
// Reset: synchronous, active low; clears scanner state, queue and output.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top #(
    parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_out_kind,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_err_code,
    output logic       o_last_of_run
);

    logic             accept;
    logic             bundle_valid;
    jsu_pkg::t_bundle front_bundle;
    jsu_pkg::t_bundle queue_bundle;
    logic             queue_empty;
    logic             queue_rd;
    logic             at_rest;

    assign accept = push && !full;

    jsu_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (accept),
        .i_in_byte      (i_in_byte),
        .i_end_of_text  (i_end_of_text),
        .o_bundle_valid (bundle_valid),
        .o_bundle       (front_bundle),
        .o_at_rest      (at_rest)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (bundle_valid),
        .i_wr_data (front_bundle),
        .i_rd      (queue_rd),
        .o_rd_data (queue_bundle),
        .o_full    (full),
        .o_empty   (queue_empty)
    );

    jsu_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bundle       (queue_bundle),
        .i_bundle_empty (queue_empty),
        .o_bundle_rd    (queue_rd),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_out_kind     (o_out_kind),
        .o_out_byte     (o_out_byte),
        .o_err_code     (o_err_code),
        .o_last_of_run  (o_last_of_run)
    );

    // An end beat always leaves the scanner waiting for a quote
    a_end_rests: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_end_of_text) |=> at_rest)
        else $error("scanner not at rest after end beat");

    // A close or error result is always the last of its item
    a_term_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_kind != jsu_pkg::KIND_BYTE) |-> o_last_of_run)
        else $error("close or error result is not last of run");

    // Error results carry no byte, content results carry no error code
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_kind == jsu_pkg::KIND_ERR) |-> (o_out_byte == 8'd0))
        else $error("error result carries a byte");

    a_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_kind == jsu_pkg::KIND_BYTE) |-> (o_err_code == 3'd0))
        else $error("content result carries an error code");

endmodule

// File: dv/json_string_unescape_utf8_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape to UTF-8, testbench
// Feeds quoted strings byte by byte, including escapes, surrogate pairs, and
// broken or truncated text. A scanner model in the driver predicts the result
// beats of every accepted input beat. The monitor compares each popped beat
// with the oldest prediction. Both sides idle at random, and the receiver
// holds off once for a long stretch so that the input side stalls.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top_test;

    localparam logic [2:0]  NO_ERR      = 3'd0;
    localparam logic [7:0]  CH_QUOTE    = 8'h22;
    localparam logic [7:0]  CH_BSL      = 8'h5C;
    localparam logic [7:0]  CH_SLASH    = 8'h2F;
    localparam logic [7:0]  CH_ZERO     = "0";
    localparam logic [20:0] CP_REPLACE  = 21'hFFFD;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned HOLD_AFTER  = 60;
    localparam int unsigned TEXT_BEATS  = 250;

    typedef enum logic [3:0] {
        SC_IDLE, SC_BODY, SC_ESC, SC_HEX, SC_HEX_BAD, SC_AFTER_HIGH,
        SC_HIGH_ESC, SC_LOW_HEX, SC_LOW_HEX_BAD, SC_CLOSED
    } t_scan;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] err;
        logic       last;
    } t_out_beat;

    typedef struct {
        logic [7:0]  b;
        logic        eot;
        int unsigned gap;
    } t_text_beat;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       push          = 1'b0;
    logic [7:0] i_in_byte     = 8'h00;
    logic       i_end_of_text = 1'b0;
    logic       pop           = 1'b0;
    logic       full;
    logic       empty;
    logic [1:0] o_out_kind;
    logic [7:0] o_out_byte;
    logic [2:0] o_err_code;
    logic       o_last_of_run;

    // Scanner model state
    t_scan       scan_st     = SC_IDLE;
    logic [15:0] code_acc    = '0;
    logic [1:0]  digit_cnt   = '0;
    logic [9:0]  high_bits   = '0;
    logic        err_latched = 1'b0;

    t_out_beat   step_out[$];
    t_out_beat   expected_q[$];
    t_text_beat  pending[$];
    t_text_beat  next_beat;
    t_out_beat   want;

    int unsigned n_items      = 0;
    int unsigned n_fail       = 0;
    int unsigned results_seen = 0;
    int unsigned beats_sent   = 0;
    int unsigned src_wait     = 0;
    int unsigned sink_wait    = 0;
    int unsigned hold_left    = 0;
    logic        hold_armed   = 1'b1;
    string       esc_set      = "\"\\/bfnrt";

    json_string_unescape_utf8_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .empty         (empty),
        .pop           (pop),
        .o_out_kind    (o_out_kind),
        .o_out_byte    (o_out_byte),
        .o_err_code    (o_err_code),
        .o_last_of_run (o_last_of_run)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Scanner model
    // ------------------------------------------------------------------
    function automatic void scanner_clear();
        scan_st     = SC_IDLE;
        code_acc    = '0;
        digit_cnt   = '0;
        high_bits   = '0;
        err_latched = 1'b0;
    endfunction

    function automatic void emit(logic [1:0] kind, logic [7:0] data, logic [2:0] code);
        t_out_beat r;
        if (step_out.size() < 4) begin
            r.kind = kind;
            r.data = data;
            r.err  = code;
            r.last = 1'b0;
            step_out = {step_out, r};
        end
    endfunction

    // Split a code point into its UTF-8 bytes
    function automatic void emit_code_point(logic [20:0] cp);
        if (cp < 21'h80) begin
            emit(jsu_pkg::KIND_BYTE, cp[7:0], NO_ERR);
        end else if (cp < 21'h800) begin
            emit(jsu_pkg::KIND_BYTE, {3'b110, cp[10:6]}, NO_ERR);
            emit(jsu_pkg::KIND_BYTE, {2'b10, cp[5:0]}, NO_ERR);
        end else if (cp < 21'h10000) begin
            emit(jsu_pkg::KIND_BYTE, {4'b1110, cp[15:12]}, NO_ERR);
            emit(jsu_pkg::KIND_BYTE, {2'b10, cp[11:6]}, NO_ERR);
            emit(jsu_pkg::KIND_BYTE, {2'b10, cp[5:0]}, NO_ERR);
        end else begin
            emit(jsu_pkg::KIND_BYTE, {5'b11110, cp[20:18]}, NO_ERR);
            emit(jsu_pkg::KIND_BYTE, {2'b10, cp[17:12]}, NO_ERR);
            emit(jsu_pkg::KIND_BYTE, {2'b10, cp[11:6]}, NO_ERR);
            emit(jsu_pkg::KIND_BYTE, {2'b10, cp[5:0]}, NO_ERR);
        end
    endfunction

    function automatic void flag_error(logic [2:0] code);
        emit(jsu_pkg::KIND_ERR, 8'h00, code);
        err_latched = 1'b1;
        scan_st     = SC_IDLE;
    endfunction

    function automatic void body_char(logic [7:0] b);
        if (b == CH_QUOTE) begin
            emit(jsu_pkg::KIND_CLOSE, 8'h00, NO_ERR);
            scan_st = SC_CLOSED;
        end else if (b < 8'h20) begin
            flag_error(jsu_pkg::ERR_CTRL);
        end else if (b == CH_BSL) begin
            scan_st = SC_ESC;
        end else begin
            emit(jsu_pkg::KIND_BYTE, b, NO_ERR);
            scan_st = SC_BODY;
        end
    endfunction

    function automatic void escape_char(logic [7:0] b);
        logic [7:0] v;
        v       = b;
        scan_st = SC_BODY;
        case (b)
            CH_QUOTE, CH_BSL, CH_SLASH: v = b;
            "b": v = 8'h08;
            "f": v = 8'h0C;
            "n": v = 8'h0A;
            "r": v = 8'h0D;
            "t": v = 8'h09;
            "u": begin
                code_acc  = '0;
                digit_cnt = '0;
                scan_st   = SC_HEX;
            end
            default: flag_error(jsu_pkg::ERR_BAD_ESC);
        endcase
        if (scan_st == SC_BODY) begin
            emit(jsu_pkg::KIND_BYTE, v, NO_ERR);
        end
    endfunction

    // Resolve four collected digits; a high half waits for its partner
    function automatic void hex_finish(logic low);
        logic is_high;
        logic is_low;
        is_high = (code_acc >= 16'hD800) && (code_acc <= 16'hDBFF);
        is_low  = (code_acc >= 16'hDC00) && (code_acc <= 16'hDFFF);
        scan_st = SC_BODY;
        if (!low) begin
            if (is_high) begin
                high_bits = code_acc[9:0];
                scan_st   = SC_AFTER_HIGH;
            end else if (is_low) begin
                emit_code_point(CP_REPLACE);
            end else begin
                emit_code_point({5'd0, code_acc});
            end
        end else if (is_low) begin
            emit_code_point(21'h10000 + {1'b0, high_bits, code_acc[9:0]});
        end else begin
            emit_code_point(CP_REPLACE);
        end
    endfunction

    function automatic logic [4:0] hex_digit(logic [7:0] b);
        if (b >= "0" && b <= "9") return {1'b1, 4'(b - CH_ZERO)};
        if (b >= "a" && b <= "f") return {1'b1, 4'(b - 8'h57)};
        if (b >= "A" && b <= "F") return {1'b1, 4'(b - 8'h37)};
        return 5'd0;
    endfunction

    // Advance the model by one accepted beat and queue what it yields
    function automatic void predict_beat(logic [7:0] b, logic eot);
        logic       bad;
        logic       low;
        logic [4:0] dig;
        step_out.delete();
        if (eot) begin
            if (!err_latched) begin
                case (scan_st)
                    SC_IDLE: flag_error(jsu_pkg::ERR_NO_QUOTE);
                    SC_BODY: flag_error(jsu_pkg::ERR_UNTERM);
                    SC_ESC:  flag_error(jsu_pkg::ERR_TRAIL_BSL);
                    SC_HEX, SC_HEX_BAD, SC_LOW_HEX, SC_LOW_HEX_BAD:
                        flag_error(jsu_pkg::ERR_TRUNC_HEX);
                    SC_AFTER_HIGH: begin
                        emit_code_point(CP_REPLACE);
                        flag_error(jsu_pkg::ERR_UNTERM);
                    end
                    SC_HIGH_ESC: begin
                        emit_code_point(CP_REPLACE);
                        flag_error(jsu_pkg::ERR_TRAIL_BSL);
                    end
                    default: ;
                endcase
            end
            scanner_clear();
        end else if (!err_latched) begin
            case (scan_st)
                SC_IDLE: begin
                    if (b == CH_QUOTE) scan_st = SC_BODY;
                    else flag_error(jsu_pkg::ERR_NO_QUOTE);
                end
                SC_BODY: body_char(b);
                SC_ESC:  escape_char(b);
                SC_HEX, SC_HEX_BAD, SC_LOW_HEX, SC_LOW_HEX_BAD: begin
                    bad = (scan_st == SC_HEX_BAD) || (scan_st == SC_LOW_HEX_BAD);
                    low = (scan_st == SC_LOW_HEX) || (scan_st == SC_LOW_HEX_BAD);
                    dig = hex_digit(b);
                    if (dig[4]) code_acc = {code_acc[11:0], dig[3:0]};
                    else bad = 1'b1;
                    if (digit_cnt == 2'd3) begin
                        digit_cnt = '0;
                        if (bad) flag_error(jsu_pkg::ERR_BAD_HEX);
                        else hex_finish(low);
                    end else begin
                        digit_cnt = digit_cnt + 2'd1;
                        if (low) scan_st = bad ? SC_LOW_HEX_BAD : SC_LOW_HEX;
                        else scan_st = bad ? SC_HEX_BAD : SC_HEX;
                    end
                end
                SC_AFTER_HIGH: begin
                    if (b == CH_BSL) begin
                        scan_st = SC_HIGH_ESC;
                    end else begin
                        emit_code_point(CP_REPLACE);
                        body_char(b);
                    end
                end
                SC_HIGH_ESC: begin
                    if (b == "u") begin
                        code_acc  = '0;
                        digit_cnt = '0;
                        scan_st   = SC_LOW_HEX;
                    end else begin
                        emit_code_point(CP_REPLACE);
                        escape_char(b);
                    end
                end
                default: ;
            endcase
        end
        if (step_out.size() > 0) begin
            step_out[step_out.size() - 1].last = 1'b1;
            expected_q = {expected_q, step_out};
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function automatic void add_beat(logic [7:0] b, logic eot);
        t_text_beat t;
        t.b   = b;
        t.eot = eot;
        // every fourth stretch of 40 beats goes without gaps
        t.gap = (((n_items / 40) % 4) == 3) ? 0 : $urandom_range(0, 19);
        pending.push_front(t);
        pending = {pending[1:$], pending[0]};
        n_items++;
    endfunction

    function automatic void add_end();
        add_beat(8'($urandom_range(0, 255)), 1'b1);
    endfunction

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++) add_beat(s[i], 1'b0);
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10) return CH_ZERO + 8'(n);
        return ($urandom_range(0, 1) ? 8'h57 : 8'h37) + 8'(n);
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (hex_digit(b) != 5'd0) b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic void add_hex4(logic [15:0] v);
        add_beat(CH_BSL, 1'b0);
        add_beat("u", 1'b0);
        for (int i = 3; i >= 0; i--) add_beat(hex_char(v[i*4 +: 4]), 1'b0);
    endfunction

    // Favor the ends of a range
    function automatic logic [15:0] pick_edge(logic [15:0] lo, logic [15:0] hi);
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        b = 8'($urandom_range(8'h20, 8'hFF));
        while (b == CH_QUOTE || b == CH_BSL) b = 8'($urandom_range(8'h20, 8'hFF));
        return b;
    endfunction

    function automatic logic [7:0] bad_escape_char();
        logic [7:0] b;
        logic       hit;
        do begin
            b   = 8'($urandom_range(0, 255));
            hit = (b == "u");
            for (int i = 0; i < esc_set.len(); i++) if (b == esc_set[i]) hit = 1'b1;
        end while (hit);
        return b;
    endfunction

    function automatic logic [15:0] bmp_value();
        case ($urandom_range(0, 3))
            0: return pick_edge(16'h0000, 16'h007F);
            1: return pick_edge(16'h0080, 16'h07FF);
            2: return pick_edge(16'h0800, 16'hD7FF);
            default: return pick_edge(16'hE000, 16'hFFFF);
        endcase
    endfunction

    // One piece of string content, mostly legal
    function automatic void add_token();
        int unsigned k;
        int unsigned pos;
        k = $urandom_range(0, 99);
        if (k < 35) begin
            add_beat(plain_char(), 1'b0);
        end else if (k < 50) begin
            add_beat(CH_BSL, 1'b0);
            add_beat(esc_set[$urandom_range(0, 7)], 1'b0);
        end else if (k < 53) begin
            add_beat(CH_BSL, 1'b0);
            add_beat(bad_escape_char(), 1'b0);
        end else if (k < 63) begin
            add_hex4(bmp_value());
        end else if (k < 73) begin
            add_hex4(pick_edge(16'hD800, 16'hDBFF));
            add_hex4(pick_edge(16'hDC00, 16'hDFFF));
        end else if (k < 77) begin
            add_hex4(pick_edge(16'hDC00, 16'hDFFF));
        end else if (k < 83) begin
            add_hex4(pick_edge(16'hD800, 16'hDBFF));
            add_beat($urandom_range(0, 3) == 0 ? CH_QUOTE : plain_char(), 1'b0);
        end else if (k < 88) begin
            add_hex4(pick_edge(16'hD800, 16'hDBFF));
            add_hex4($urandom_range(0, 1) ? pick_edge(16'h0000, 16'hDBFF)
                                          : pick_edge(16'hE000, 16'hFFFF));
        end else if (k < 93) begin
            add_hex4(pick_edge(16'hD800, 16'hDBFF));
            add_beat(CH_BSL, 1'b0);
            add_beat($urandom_range(0, 4) == 0 ? bad_escape_char()
                                               : esc_set[$urandom_range(0, 7)], 1'b0);
        end else if (k < 96) begin
            pos = $urandom_range(0, 3);
            add_beat(CH_BSL, 1'b0);
            add_beat("u", 1'b0);
            for (int i = 0; i < 4; i++)
                add_beat(i == pos ? non_hex_char() : hex_char(4'($urandom_range(0, 15))), 1'b0);
        end else begin
            add_beat(8'($urandom_range(0, 8'h1F)), 1'b0);
        end
    endfunction

    // One text up to its end beat: mostly a quoted string, sometimes noise
    function automatic void add_random_text();
        int unsigned fin;
        logic [7:0]  first;
        if ($urandom_range(0, 99) < 5) begin
            first = 8'($urandom_range(0, 255));
            if (first == CH_QUOTE) first = 8'h00;
            add_beat(first, 1'b0);
            repeat ($urandom_range(0, 3)) add_beat(8'($urandom_range(0, 255)), 1'b0);
            add_end();
            return;
        end
        add_beat(CH_QUOTE, 1'b0);
        repeat ($urandom_range(0, 6)) add_token();
        fin = $urandom_range(0, 99);
        if (fin < 70) begin
            add_beat(CH_QUOTE, 1'b0);
        end else if (fin < 78) begin
            add_beat(CH_QUOTE, 1'b0);
            repeat ($urandom_range(1, 3)) add_beat(8'($urandom_range(0, 255)), 1'b0);
        end else if (fin < 85) begin
            // leave the string open
        end else if (fin < 89) begin
            add_beat(CH_BSL, 1'b0);
        end else if (fin < 94) begin
            add_beat(CH_BSL, 1'b0);
            add_beat("u", 1'b0);
            repeat ($urandom_range(0, 3)) add_beat(hex_char(4'($urandom_range(0, 15))), 1'b0);
        end else begin
            add_hex4(pick_edge(16'hD800, 16'hDBFF));
            if ($urandom_range(0, 1)) add_beat(CH_BSL, 1'b0);
        end
        add_end();
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer pending beats, predict each one as it is taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push     <= 1'b0;
            src_wait = 0;
            scanner_clear();
        end else begin
            if (push && !full) begin
                predict_beat(i_in_byte, i_end_of_text);
                beats_sent <= beats_sent + 1;
            end
            if (!push || !full) begin
                if (pending.size() == 0) begin
                    push <= 1'b0;
                end else if (src_wait < pending[0].gap) begin
                    src_wait++;
                    push <= 1'b0;
                end else begin
                    next_beat     = pending.pop_front();
                    src_wait      = 0;
                    push          <= 1'b1;
                    i_in_byte     <= next_beat.b;
                    i_end_of_text <= next_beat.eot;
                end
            end
        end
    end

    // Long receiver hold-off once traffic is under way
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end else if (hold_armed && beats_sent >= HOLD_AFTER) begin
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check every popped beat against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop       <= 1'b0;
            sink_wait = 0;
        end else begin
            if (pop && !empty) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result beat: kind %0d byte %02h err %0d",
                           o_out_kind, o_out_byte, o_err_code);
                    n_fail++;
                end else begin
                    want = expected_q.pop_front();
                    if (o_out_kind !== want.kind) begin
                        $error("out_kind mismatch: expected %0d, got %0d",
                               want.kind, o_out_kind);
                        n_fail++;
                    end
                    if (o_out_byte !== want.data) begin
                        $error("out_byte mismatch: expected %02h, got %02h",
                               want.data, o_out_byte);
                        n_fail++;
                    end
                    if (o_err_code !== want.err) begin
                        $error("err_code mismatch: expected %0d, got %0d",
                               want.err, o_err_code);
                        n_fail++;
                    end
                    if (o_last_of_run !== want.last) begin
                        $error("last_of_run mismatch: expected %0d, got %0d",
                               want.last, o_last_of_run);
                        n_fail++;
                    end
                end
                results_seen++;
                // every third stretch of 50 results pops back to back
                sink_wait = (((results_seen / 50) % 3) == 2) ? 0 : $urandom_range(0, 19);
            end
            if (hold_left != 0 || sink_wait != 0) begin
                pop <= 1'b0;
                if (sink_wait != 0) sink_wait--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        // end with nothing open, then noise before a quote
        add_end();
        add_beat(8'h00, 1'b0);
        add_beat(8'hFF, 1'b0);
        add_end();
        // top byte, DEL, an escape, then a raw control byte
        add_beat(CH_QUOTE, 1'b0);
        add_beat(8'hFF, 1'b0);
        add_beat(8'h7F, 1'b0);
        add_str("\\t");
        add_beat(8'h1F, 1'b0);
        add_end();
        // highest BMP escape, then a backslash cut off by the end
        add_str("\"\\uFFFF\\");
        add_end();
        // empty string, a byte after the close, then the end
        add_str("\"\"x");
        add_end();

        while (n_items < TEXT_BEATS) add_random_text();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || push) @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (n_fail == 0) begin
            $display("json_string_unescape_utf8_top test passed");
        end else begin
            $display("json_string_unescape_utf8_top test failed");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("json_string_unescape_utf8_top test failed");
        $finish;
    end

endmodule

// File: files.f
src/jsu_pkg.sv
src/jsu_front.sv
src/jsu_queue.sv
src/jsu_back.sv
src/json_string_unescape_utf8_top.sv
dv/json_string_unescape_utf8_top_test.sv
